/* rtl/tkh_pkg.sv */
`default_nettype none

package tkh_pkg;

   localparam int PRI_W  = 32;
   localparam int WORD_W = 32;
   localparam int CAP_W  = 5;

   // Priority of a slot that holds no item.
   localparam logic signed [PRI_W-1:0] MARKER = -32'sd2147483647;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_READ   = 1'b1;

   typedef struct packed {
      logic                    action;
      logic signed [PRI_W-1:0] priority_req;
      logic [WORD_W-1:0]       payload;
   } req_word_type;

   typedef struct packed {
      logic                    entry_valid;
      logic signed [PRI_W-1:0] entry_priority;
      logic [WORD_W-1:0]       entry_payload;
      logic [CAP_W-1:0]        held_count;
      logic                    last;
   } rsp_word_type;

endpackage

`default_nettype wire

/* rtl/tkh_slot_ram.sv */
`default_nettype none

module tkh_slot_ram
   import tkh_pkg::*;
#(
   parameter int DEPTH   = 16,
   parameter int STORE_W = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr_b,
   output logic signed [PRI_W-1:0]         rd_pri_a,
   output logic signed [PRI_W-1:0]         rd_pri_b,
   output logic [STORE_W-1:0]              rd_pay_a,
   output logic [STORE_W-1:0]              rd_pay_b,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic signed [PRI_W-1:0]    wr_pri,
   input  wire logic [STORE_W-1:0]         wr_pay
);

   logic signed [PRI_W-1:0] pri_mem [DEPTH];
   logic [STORE_W-1:0]      pay_mem [DEPTH];
   logic [DEPTH-1:0]        vld_ff;

   // A slot never written since reset reads as the empty marker.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pri_mem[wr_addr] <= wr_pri;
         pay_mem[wr_addr] <= wr_pay;
      end
   end

   always_ff @(posedge clock) begin
      rd_pri_a <= vld_ff[rd_addr_a] ? pri_mem[rd_addr_a] : MARKER;
      rd_pri_b <= vld_ff[rd_addr_b] ? pri_mem[rd_addr_b] : MARKER;
      rd_pay_a <= pay_mem[rd_addr_a];
      rd_pay_b <= pay_mem[rd_addr_b];
   end

endmodule

`default_nettype wire

/* rtl/tkh_seq.sv */
`default_nettype none

module tkh_seq
   import tkh_pkg::*;
#(
   parameter int DEPTH   = 16,
   parameter int STORE_W = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire req_word_type               req_word,
   input  wire logic [$clog2(DEPTH):0]     cap,
   output logic                            rsp_strobe,
   output rsp_word_type                    rsp_word,
   output logic [$clog2(DEPTH)-1:0]        rd_addr_a,
   output logic [$clog2(DEPTH)-1:0]        rd_addr_b,
   input  wire logic signed [PRI_W-1:0]    rd_pri_a,
   input  wire logic signed [PRI_W-1:0]    rd_pri_b,
   input  wire logic [STORE_W-1:0]         rd_pay_a,
   input  wire logic [STORE_W-1:0]         rd_pay_b,
   output logic                            wr_en,
   output logic [$clog2(DEPTH)-1:0]        wr_addr,
   output logic signed [PRI_W-1:0]         wr_pri,
   output logic [STORE_W-1:0]              wr_pay
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = IW + 1;
   localparam int KW = IW + 2;
   localparam int XW = (CW > CAP_W) ? CW : CAP_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROOT,
      S_NEXT,
      S_CMP,
      S_SCAN
   } state_type;

   state_type               state_ff, state_in;
   logic                    busy_ff, busy_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   rsp_word_type            rsp_word_ff, rsp_word_in;
   logic [CAP_W-1:0]        ins_cnt_ff, ins_cnt_in;
   logic signed [PRI_W-1:0] item_pri_ff, item_pri_in;
   logic [STORE_W-1:0]      item_pay_ff, item_pay_in;
   logic [IW-1:0]           off_ff, off_in;
   logic [CW-1:0]           scan_idx_ff, scan_idx_in;
   logic                    rd_live_ff, rd_live_in;
   logic                    have_pend_ff, have_pend_in;
   logic signed [PRI_W-1:0] pend_pri_ff, pend_pri_in;
   logic [STORE_W-1:0]      pend_pay_ff, pend_pay_in;

   logic [KW-1:0]           c1;
   logic [KW-1:0]           c2;
   logic                    take_b;
   logic signed [PRI_W-1:0] child_pri;
   logic [STORE_W-1:0]      child_pay;
   logic [IW-1:0]           child_addr;

   assign c1 = KW'({off_ff, 1'b1});
   assign c2 = c1 + KW'(1);

   // Child compare path: the smaller child, ties going to the left one.
   assign take_b     = (c2 < KW'(cap)) && (rd_pri_a > rd_pri_b);
   assign child_pri  = take_b ? rd_pri_b : rd_pri_a;
   assign child_pay  = take_b ? rd_pay_b : rd_pay_a;
   assign child_addr = take_b ? c2[IW-1:0] : c1[IW-1:0];

   always_comb begin
      state_in      = state_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      ins_cnt_in    = ins_cnt_ff;
      item_pri_in   = item_pri_ff;
      item_pay_in   = item_pay_ff;
      off_in        = off_ff;
      scan_idx_in   = scan_idx_ff;
      rd_live_in    = 1'b0;
      have_pend_in  = have_pend_ff;
      pend_pri_in   = pend_pri_ff;
      pend_pay_in   = pend_pay_ff;
      rd_addr_a     = c1[IW-1:0];
      rd_addr_b     = c2[IW-1:0];
      wr_en         = 1'b0;
      wr_addr       = off_ff;
      wr_pri        = item_pri_ff;
      wr_pay        = item_pay_ff;

      unique case (state_ff)
         S_IDLE: begin
            rd_addr_a = '0;
            if (start) begin
               if (req_word.action == ACT_INSERT) begin
                  item_pri_in = req_word.priority_req;
                  item_pay_in = req_word.payload[STORE_W-1:0];
                  off_in      = '0;
                  if (XW'(ins_cnt_ff) < XW'(cap)) begin
                     ins_cnt_in = ins_cnt_ff + CAP_W'(1);
                  end
                  state_in = S_ROOT;
               end else begin
                  scan_idx_in  = '0;
                  have_pend_in = 1'b0;
                  state_in     = S_SCAN;
               end
            end
         end
         S_ROOT: begin
            // The root holds the smallest kept priority.
            if (rd_pri_a < item_pri_ff) begin
               state_in = S_NEXT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_NEXT: begin
            if (c1 >= KW'(cap)) begin
               wr_en    = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            wr_en = 1'b1;
            if (child_pri < item_pri_ff) begin
               // The child moves up into the hole; the item goes on down.
               wr_pri   = child_pri;
               wr_pay   = child_pay;
               off_in   = child_addr;
               state_in = S_NEXT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            rd_addr_a = scan_idx_ff[IW-1:0];
            // Each held entry is kept pending until the next one is found, so the final one can carry last.
            if (rd_live_ff && (rd_pri_a != MARKER)) begin
               if (have_pend_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_word_in   = '{entry_valid: 1'b1, entry_priority: pend_pri_ff,
                                    entry_payload: WORD_W'(pend_pay_ff),
                                    held_count: ins_cnt_ff, last: 1'b0};
               end
               have_pend_in = 1'b1;
               pend_pri_in  = rd_pri_a;
               pend_pay_in  = rd_pay_a;
            end
            if (scan_idx_ff < cap) begin
               scan_idx_in = scan_idx_ff + CW'(1);
               rd_live_in  = 1'b1;
            end else if (!rd_live_ff) begin
               rsp_strobe_in = 1'b1;
               if (have_pend_ff) begin
                  rsp_word_in = '{entry_valid: 1'b1, entry_priority: pend_pri_ff,
                                  entry_payload: WORD_W'(pend_pay_ff),
                                  held_count: ins_cnt_ff, last: 1'b1};
               end else begin
                  rsp_word_in = '{entry_valid: 1'b0, entry_priority: '0,
                                  entry_payload: '0,
                                  held_count: ins_cnt_ff, last: 1'b1};
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      busy_in = (state_in != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         ins_cnt_ff    <= '0;
         rd_live_ff    <= 1'b0;
         have_pend_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         busy_ff       <= busy_in;
         rsp_strobe_ff <= rsp_strobe_in;
         ins_cnt_ff    <= ins_cnt_in;
         rd_live_ff    <= rd_live_in;
         have_pend_ff  <= have_pend_in;
      end
      rsp_word_ff <= rsp_word_in;
      item_pri_ff <= item_pri_in;
      item_pay_ff <= item_pay_in;
      off_ff      <= off_in;
      scan_idx_ff <= scan_idx_in;
      pend_pri_ff <= pend_pri_in;
      pend_pay_ff <= pend_pay_in;
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

`default_nettype wire

/* rtl/top_k_min_heap_selector_top.sv */
`default_nettype none

// Keeps the capacity highest-priority words seen in a min-heap of slots.
// A word is taken at a clock edge with start high and busy low. An insert
// keeps busy high until it is done: it first reads the root, then each
// heap level has a read step, to fetch both children from the two-port
// slot memory, and a step to compare and write through its single write
// port. A read-out walks the slot memory one address a cycle, giving at
// most one result word a cycle. Every result sits on rsp_word for exactly
// one cycle under rsp_strobe, and the receiver must take it then, since
// the block cannot be held off. The capacity register is taken whenever
// csr_valid is high and should be written only while idle.
module top_k_min_heap_selector_top
   import tkh_pkg::*;
#(
   parameter int DEPTH         = 16,
   parameter int PAYLOAD_WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire req_word_type       req_word,
   output logic                    rsp_strobe,
   output rsp_word_type            rsp_word,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [CAP_W-1:0]   csr_data
);

   localparam int IW      = $clog2(DEPTH);
   localparam int CW      = IW + 1;
   localparam int STORE_W = (PAYLOAD_WIDTH < WORD_W) ? PAYLOAD_WIDTH : WORD_W;

   logic [CAP_W-1:0]        csr_ff;
   logic [CW-1:0]           cap;
   logic [IW-1:0]           rd_addr_a;
   logic [IW-1:0]           rd_addr_b;
   logic signed [PRI_W-1:0] rd_pri_a;
   logic signed [PRI_W-1:0] rd_pri_b;
   logic [STORE_W-1:0]      rd_pay_a;
   logic [STORE_W-1:0]      rd_pay_b;
   logic                    wr_en;
   logic [IW-1:0]           wr_addr;
   logic signed [PRI_W-1:0] wr_pri;
   logic [STORE_W-1:0]      wr_pay;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         csr_ff <= csr_data;
      end
   end

   // A capacity of zero acts as one, and one above the slot count as full.
   always_comb begin
      priority if (csr_ff == '0) begin
         cap = CW'(1);
      end else if (int'(csr_ff) > DEPTH) begin
         cap = CW'(DEPTH);
      end else begin
         cap = CW'(csr_ff);
      end
   end

   tkh_seq #(
      .DEPTH   (DEPTH),
      .STORE_W (STORE_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .cap        (cap),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b),
      .rd_pri_a   (rd_pri_a),
      .rd_pri_b   (rd_pri_b),
      .rd_pay_a   (rd_pay_a),
      .rd_pay_b   (rd_pay_b),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_pri     (wr_pri),
      .wr_pay     (wr_pay)
   );

   tkh_slot_ram #(
      .DEPTH   (DEPTH),
      .STORE_W (STORE_W)
   ) u_slot_ram (
      .clock     (clock),
      .reset     (reset),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_pri_a  (rd_pri_a),
      .rd_pri_b  (rd_pri_b),
      .rd_pay_a  (rd_pay_a),
      .rd_pay_b  (rd_pay_b),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_pri    (wr_pri),
      .wr_pay    (wr_pay)
   );

   // A word that is not the final one of a read-out comes while still busy.
   a_mid_word_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_word.last) |-> busy)
      else $error("read-out word without last came while idle");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_word.entry_valid) |-> rsp_word.last)
      else $error("empty read-out word without last");

   a_read_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_word.action == ACT_READ)) |=> (busy && !rsp_strobe))
      else $error("read-out did not enter its walk");

   a_insert_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_word.action == ACT_INSERT)) |=> !rsp_strobe)
      else $error("insert produced a result word");

endmodule

`default_nettype wire

/* dv/top_k_min_heap_selector_top_tb.sv */
`timescale 1ns / 1ps

module top_k_min_heap_selector_top_tb;
   import tkh_pkg::*;

   localparam int DEPTH         = 16;
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 12;
   localparam logic signed [PRI_W-1:0] PRI_MAX = 32'sh7fff_ffff;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   req_word_type       req_word;
   logic               rsp_strobe;
   rsp_word_type       rsp_word;
   logic               csr_valid;
   logic               csr_ready;
   logic [CAP_W-1:0]   csr_data;

   // Shadow copy of the heap, the insert counter and the capacity register.
   logic signed [PRI_W-1:0] heap_pri [DEPTH];
   logic [WORD_W-1:0]       heap_pay [DEPTH];
   logic [CAP_W-1:0]        seen_count;
   logic [CAP_W-1:0]        cap_reg;

   rsp_word_type pending_entries [$];
   rsp_word_type want;
   int           error_count = 0;
   int           idle_cycles = 0;

   top_k_min_heap_selector_top #(
      .DEPTH         (DEPTH),
      .PAYLOAD_WIDTH (WORD_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned eff_capacity();
      if (cap_reg == 0) return 1;
      if (cap_reg > DEPTH) return DEPTH;
      return 32'(cap_reg);
   endfunction

   function automatic void heap_insert(input logic signed [PRI_W-1:0] pri,
                                       input logic [WORD_W-1:0] pay);
      int unsigned k, pos, c1, c2, pick;
      logic signed [PRI_W-1:0] tp;
      logic [WORD_W-1:0]       tw;
      k = eff_capacity();
      pos = 0;
      if (seen_count < k) seen_count = seen_count + 1'b1;
      if (!(heap_pri[0] < pri)) return;
      heap_pri[0] = pri;
      heap_pay[0] = pay;
      c1 = 1;
      while (c1 < k) begin
         c2 = c1 + 1;
         pick = (c2 < k && heap_pri[c1] > heap_pri[c2]) ? c2 : c1;
         if (!(heap_pri[pick] < heap_pri[pos])) break;
         tp = heap_pri[pos];
         tw = heap_pay[pos];
         heap_pri[pos] = heap_pri[pick];
         heap_pay[pos] = heap_pay[pick];
         heap_pri[pick] = tp;
         heap_pay[pick] = tw;
         pos = pick;
         c1 = 2 * pos + 1;
      end
   endfunction

   function automatic void heap_readout();
      int unsigned k, i, total, seq;
      rsp_word_type e;
      k = eff_capacity();
      total = 0;
      seq = 0;
      for (i = 0; i < k; i++) begin
         if (heap_pri[i] != MARKER) total++;
      end
      if (total == 0) begin
         e = '0;
         e.held_count = seen_count;
         e.last = 1'b1;
         pending_entries.push_back(e);
      end else begin
         for (i = 0; i < k; i++) begin
            if (heap_pri[i] != MARKER) begin
               seq++;
               e.entry_valid    = 1'b1;
               e.entry_priority = heap_pri[i];
               e.entry_payload  = heap_pay[i];
               e.held_count     = seen_count;
               e.last           = (seq == total);
               pending_entries.push_back(e);
            end
         end
      end
   endfunction

   function automatic logic signed [PRI_W-1:0] rand_priority();
      logic signed [PRI_W-1:0] p;
      case ($urandom_range(0, 7))
         0: p = PRI_MAX;
         1: p = MARKER;
         2: p = MARKER + $urandom_range(1, 4);
         3, 4: begin
            p = $urandom_range(0, 16);
            p = p - 8;
         end
         default: begin
            p = $urandom;
            // The most negative value lies outside the priority range.
            if (p == {1'b1, {(PRI_W-1){1'b0}}}) p = MARKER;
         end
      endcase
      return p;
   endfunction

   function automatic req_word_type mk_insert(input logic signed [PRI_W-1:0] pri,
                                              input logic [WORD_W-1:0] pay);
      req_word_type w;
      w.action       = ACT_INSERT;
      w.priority_req = pri;
      w.payload      = pay;
      return w;
   endfunction

   function automatic req_word_type mk_readout();
      req_word_type w;
      w.action       = ACT_READ;
      w.priority_req = rand_priority();
      w.payload      = $urandom;
      return w;
   endfunction

   // Start is left high after acceptance so that a following word can go
   // back to back; pause or drain lowers it.
   task automatic send_word(input req_word_type w);
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy !== 1'b0);
      if (w.action == ACT_INSERT) heap_insert(w.priority_req, w.payload);
      else heap_readout();
   endtask

   task automatic pause(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Insert words leave no result words to wait for, so drain also waits for
   // busy to drop, which covers a sift-down that may still be running.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_entries.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      cap_reg = v;
   endtask

   task automatic test_empty_readout();
      send_word(mk_readout());
      drain();
   endtask

   task automatic test_priority_extremes();
      send_word(mk_insert(PRI_MAX, 32'h0000_0000));
      send_word(mk_insert(MARKER, 32'hffff_ffff));
      send_word(mk_insert(MARKER + 1, 32'ha5a5_a5a5));
      send_word(mk_insert(32'sd0, 32'h5a5a_5a5a));
      send_word(mk_insert(-32'sd1, 32'hffff_ffff));
      pause(3);
      send_word(mk_insert(PRI_MAX, 32'h1234_5678));
      send_word(mk_readout());
      drain();
   endtask

   task automatic test_capacity_range();
      write_capacity(5'd1);
      send_word(mk_insert(32'sd100, 32'hc001_0001));
      send_word(mk_insert(32'sd50, 32'hc001_0002));
      send_word(mk_insert(32'sd200, 32'hc001_0003));
      send_word(mk_readout());
      drain();
      write_capacity(5'd0);
      send_word(mk_insert(-32'sd5, 32'hc002_0001));
      send_word(mk_insert(PRI_MAX, 32'hc002_0002));
      send_word(mk_readout());
      drain();
      write_capacity(5'd31);
      send_word(mk_insert(32'sd7, 32'hc003_0001));
      send_word(mk_insert(32'sd8, 32'hc003_0002));
      send_word(mk_readout());
      drain();
      // Shrinking leaves the insert count above the new capacity.
      write_capacity(5'd3);
      send_word(mk_readout());
      drain();
      write_capacity(CAP_RESET);
   endtask

   task automatic run_phase(input logic [CAP_W-1:0] cap, input int n_words);
      int sent, burst, i;
      bit held_off;
      write_capacity(cap);
      sent = 0;
      held_off = 1'b0;
      while (sent < n_words) begin
         burst = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 5);
         for (i = 0; i < burst && sent < n_words; i++) begin
            if ($urandom_range(0, 5) == 0) send_word(mk_readout());
            else send_word(mk_insert(rand_priority(), $urandom));
            sent++;
         end
         if (!held_off && sent >= n_words / 2) begin
            drain();
            held_off = 1'b1;
         end else begin
            pause($urandom_range(1, 6));
         end
      end
      send_word(mk_readout());
      drain();
   endtask

   task automatic test_random_traffic();
      run_phase(5'd16, 15);
      run_phase(5'd1, 15);
      run_phase(5'd0, 15);
      run_phase(5'd31, 15);
      run_phase(5'd5, 15);
      run_phase(5'd2, 15);
      run_phase(5'd16, 15);
      run_phase(CAP_W'($urandom_range(0, 31)), 15);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe !== 1'b0) begin
         if (pending_entries.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected result word: valid=%0d pri=%0d pay=%h cnt=%0d last=%0d",
                        rsp_word.entry_valid, rsp_word.entry_priority,
                        rsp_word.entry_payload, rsp_word.held_count, rsp_word.last);
         end else begin
            want = pending_entries.pop_front();
            if (rsp_word.entry_valid !== want.entry_valid ||
                rsp_word.entry_priority !== want.entry_priority ||
                rsp_word.entry_payload !== want.entry_payload ||
                rsp_word.held_count !== want.held_count ||
                rsp_word.last !== want.last) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("mismatch: expected valid=%0d pri=%0d pay=%h cnt=%0d last=%0d",
                           want.entry_valid, want.entry_priority, want.entry_payload,
                           want.held_count, want.last);
                  $display("          actual   valid=%0d pri=%0d pay=%h cnt=%0d last=%0d",
                           rsp_word.entry_valid, rsp_word.entry_priority,
                           rsp_word.entry_payload, rsp_word.held_count, rsp_word.last);
               end
            end
         end
      end
      if ((start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1 ||
          (csr_valid === 1'b1 && csr_ready === 1'b1))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("top_k_min_heap_selector_top_tb: done, errors");
      $finish;
   end

   initial begin
      int i;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_word  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      for (i = 0; i < DEPTH; i++) begin
         heap_pri[i] = MARKER;
         heap_pay[i] = '0;
      end
      seen_count = '0;
      cap_reg    = CAP_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_readout();
      test_priority_extremes();
      test_capacity_range();
      test_random_traffic();

      if (pending_entries.size() != 0) begin
         error_count++;
         $display("result words never seen: %0d", pending_entries.size());
      end
      if (error_count == 0) begin
         $display("top_k_min_heap_selector_top_tb: done, clean");
      end else begin
         $display("top_k_min_heap_selector_top_tb: done, errors");
      end
      $finish;
   end

endmodule
